>>> src/pgm_pkg.sv
`default_nettype none
package pgm_pkg;
    localparam int MaxElements = 32;
    localparam int MaxClasses  = 4;
    localparam int ElemW       = 6;
    localparam int ClassW      = 2;

    typedef enum logic [2:0] {
        K_LIT   = 3'd0,
        K_ONE   = 3'd1,
        K_STAR  = 3'd2,
        K_CLASS = 3'd3,
        K_INV   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        M_NORMAL      = 2'd0,
        M_ESCAPE      = 2'd1,
        M_CLASS_FIRST = 2'd2,
        M_CLASS_BODY  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        A_PAT_BYTE = 2'd0,
        A_PAT_END  = 2'd1,
        A_TXT_BYTE = 2'd2,
        A_TXT_END  = 2'd3
    } t_action;

    localparam logic [1:0] ErrNone    = 2'd0;
    localparam logic [1:0] ErrInvalid = 2'd1;
    localparam logic [1:0] ErrLong    = 2'd2;

    localparam logic [2:0] StMatch   = 3'd3;
    localparam logic [2:0] StNoMatch = 3'd4;

    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChStar   = 8'h2A;
    localparam logic [7:0] ChQuest  = 8'h3F;
    localparam logic [7:0] ChLBrack = 8'h5B;
    localparam logic [7:0] ChBang   = 8'h21;
    localparam logic [7:0] ChRBrack = 8'h5D;
    localparam logic [7:0] ChBslash = 8'h5C;

    localparam logic [0:0] RegSepSet = 1'd0;
endpackage
`default_nettype wire

>>> src/path_glob_matcher_top.sv
`default_nettype none
// channel  | handshake          | payload
// in       | i_valid / o_ready  | i_action, i_data_byte
// out      | o_valid / i_ready  | o_status, o_element_total
// cfg      | APB write/read     | separator_set at 0x0
// One word per cycle: an input register feeds the parse and automaton logic,
// a result register holds pattern end and text end results.
// The block takes a word each cycle unless a word waits in the input register while a result waits and i_ready is low.
// Reset (synchronous, active low) restores the empty open pattern state.
// Class bitmaps are cleared when a class opens; element tables need no clear.
module path_glob_matcher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [2:0]  o_status,
    output logic      [5:0]  o_element_total,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int N = pgm_pkg::MaxElements;

    logic r_sep_set;
    logic r_in_valid;
    pgm_pkg::t_action r_in_action;
    logic [7:0] r_in_byte;

    pgm_pkg::t_kind r_kind [N];
    logic [7:0]     r_char [N];
    logic [pgm_pkg::MaxClasses-1:0][255:0] r_bitmap, n_bitmap;
    logic [N:0] r_active, n_active;
    pgm_pkg::t_mode r_mode, n_mode;
    logic [pgm_pkg::ElemW-1:0] r_count, n_count;
    logic [2:0] r_ccount, n_ccount;
    logic [1:0] r_err, n_err;
    logic r_match, n_match;
    logic r_closed, n_closed;
    logic r_inv, n_inv;

    logic r_out_valid;
    logic [2:0] r_out_status;
    logic [5:0] r_out_total;

    logic w_stall;
    logic w_wr_en;
    logic [pgm_pkg::ElemW-2:0] w_wr_idx;
    pgm_pkg::t_kind w_wr_kind;
    logic [7:0] w_wr_char;
    logic w_inv_en;
    logic w_res;
    logic [2:0] w_res_status;
    logic w_sep;
    logic [N:0] w_closed, w_next;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_sep_set};
    assign w_stall = r_out_valid && !i_ready;
    assign o_ready = !(r_in_valid && w_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_set <= 1'b0;
        end else if (psel && penable && pwrite && paddr == {pgm_pkg::RegSepSet, 1'b0}) begin
            r_sep_set <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_action <= pgm_pkg::t_action'(i_action);
            r_in_byte   <= i_data_byte;
        end
    end

    assign w_sep = (r_in_byte == pgm_pkg::ChSlash) ||
                   (r_sep_set && (r_in_byte == pgm_pkg::ChBslash ||
                                  r_in_byte == pgm_pkg::ChColon));

    pgm_nfa u_nfa (
        .i_active (r_active),
        .i_count  (r_count),
        .i_kind   (r_kind),
        .i_char   (r_char),
        .i_bitmap (r_bitmap),
        .i_byte   (r_in_byte),
        .i_sep    (w_sep),
        .o_closed (w_closed),
        .o_next   (w_next)
    );

    always_comb begin
        logic fresh;
        logic full;
        n_active  = r_active;
        n_mode    = r_mode;
        n_count   = r_count;
        n_ccount  = r_ccount;
        n_err     = r_err;
        n_match   = r_match;
        n_closed  = r_closed;
        n_inv     = r_inv;
        n_bitmap  = r_bitmap;
        w_wr_en   = 1'b0;
        w_wr_idx  = r_count[pgm_pkg::ElemW-2:0];
        w_wr_kind = pgm_pkg::K_LIT;
        w_wr_char = r_in_byte;
        w_inv_en  = 1'b0;
        w_res     = 1'b0;
        w_res_status = pgm_pkg::StNoMatch;
        fresh = 1'b0;
        full  = (r_count >= pgm_pkg::ElemW'(N));
        if (r_in_valid && !w_stall) begin
            if ((r_in_action == pgm_pkg::A_PAT_BYTE || r_in_action == pgm_pkg::A_PAT_END)
                && r_closed) begin
                fresh    = 1'b1;
                n_active = (N+1)'(1);
                n_mode   = pgm_pkg::M_NORMAL;
                n_inv    = 1'b0;
                n_count  = '0;
                n_ccount = '0;
                n_err    = pgm_pkg::ErrNone;
                n_match  = 1'b0;
                n_closed = 1'b0;
                full     = 1'b0;
            end
            case (r_in_action)
                pgm_pkg::A_PAT_BYTE: begin
                    if (n_err == pgm_pkg::ErrNone) begin
                        case (n_mode)
                            pgm_pkg::M_ESCAPE: begin
                                n_mode = pgm_pkg::M_NORMAL;
                                if (full) n_err = pgm_pkg::ErrLong;
                                else w_wr_en = 1'b1;
                            end
                            pgm_pkg::M_CLASS_FIRST, pgm_pkg::M_CLASS_BODY: begin
                                if (n_mode == pgm_pkg::M_CLASS_FIRST
                                    && r_in_byte == pgm_pkg::ChBang) begin
                                    n_inv    = 1'b1;
                                    w_inv_en = 1'b1;
                                    n_mode   = pgm_pkg::M_CLASS_BODY;
                                end else if (r_in_byte == pgm_pkg::ChRBrack) begin
                                    n_mode = pgm_pkg::M_NORMAL;
                                end else begin
                                    n_bitmap[r_ccount[pgm_pkg::ClassW-1:0] - 2'd1][r_in_byte]
                                        = 1'b1;
                                    n_mode = pgm_pkg::M_CLASS_BODY;
                                end
                            end
                            default: begin
                                if (r_in_byte == pgm_pkg::ChBslash) begin
                                    n_mode = pgm_pkg::M_ESCAPE;
                                end else if (r_in_byte == pgm_pkg::ChLBrack) begin
                                    if (full || n_ccount >= 3'(pgm_pkg::MaxClasses)) begin
                                        n_err = pgm_pkg::ErrLong;
                                    end else begin
                                        n_bitmap[n_ccount[pgm_pkg::ClassW-1:0]] = '0;
                                        w_wr_en   = 1'b1;
                                        w_wr_kind = pgm_pkg::K_CLASS;
                                        w_wr_char = 8'(n_ccount);
                                        n_ccount  = n_ccount + 3'd1;
                                        n_inv     = 1'b0;
                                        n_mode    = pgm_pkg::M_CLASS_FIRST;
                                    end
                                end else if (full) begin
                                    n_err = pgm_pkg::ErrLong;
                                end else begin
                                    w_wr_en = 1'b1;
                                    if (r_in_byte == pgm_pkg::ChStar) begin
                                        w_wr_kind = pgm_pkg::K_STAR;
                                        w_wr_char = 8'd0;
                                    end else if (r_in_byte == pgm_pkg::ChQuest) begin
                                        w_wr_kind = pgm_pkg::K_ONE;
                                        w_wr_char = 8'd0;
                                    end
                                end
                            end
                        endcase
                        if (w_wr_en) n_count = n_count + 1'b1;
                    end
                end
                pgm_pkg::A_PAT_END: begin
                    if (n_err == pgm_pkg::ErrNone && n_mode != pgm_pkg::M_NORMAL)
                        n_err = pgm_pkg::ErrInvalid;
                    n_closed = 1'b1;
                    n_active = (N+1)'(1);
                    n_match  = 1'b0;
                    w_res    = 1'b1;
                    w_res_status = {1'b0, n_err};
                end
                pgm_pkg::A_TXT_BYTE: begin
                    if (r_closed && r_err == pgm_pkg::ErrNone) begin
                        if (w_sep && w_closed[r_count]) n_match = 1'b1;
                        n_active = w_next;
                    end
                end
                default: begin
                    w_res = 1'b1;
                    if (!r_closed) w_res_status = pgm_pkg::StNoMatch;
                    else if (r_err != pgm_pkg::ErrNone) w_res_status = {1'b0, r_err};
                    else if (r_count == '0 || r_match || w_closed[r_count])
                        w_res_status = pgm_pkg::StMatch;
                    else w_res_status = pgm_pkg::StNoMatch;
                    n_active = (N+1)'(1);
                    n_match  = 1'b0;
                end
            endcase
        end
        if (fresh) w_wr_idx = '0;
        if (w_inv_en) w_wr_idx = 5'(r_count - 1'b1);
    end

    // element tables: plain writes, only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_kind[w_wr_idx] <= w_wr_kind;
            r_char[w_wr_idx] <= w_wr_char;
        end else if (w_inv_en && r_count != '0) begin
            r_kind[w_wr_idx] <= pgm_pkg::K_INV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= (N+1)'(1);
            r_mode   <= pgm_pkg::M_NORMAL;
            r_count  <= '0;
            r_ccount <= '0;
            r_err    <= pgm_pkg::ErrNone;
            r_match  <= 1'b0;
            r_closed <= 1'b0;
            r_inv    <= 1'b0;
            r_bitmap <= '0;
        end else begin
            r_active <= n_active;
            r_mode   <= n_mode;
            r_count  <= n_count;
            r_ccount <= n_ccount;
            r_err    <= n_err;
            r_match  <= n_match;
            r_closed <= n_closed;
            r_inv    <= n_inv;
            r_bitmap <= n_bitmap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_stall) begin
            r_out_valid <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall && w_res) begin
            r_out_status <= w_res_status;
            r_out_total  <= n_count;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_element_total = r_out_total;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pgm_pkg::ElemW'(N))
        else $error("element count out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("result changed under stall");
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccount <= 3'(pgm_pkg::MaxClasses))
        else $error("class count out of range");
endmodule
`default_nettype wire

>>> src/pgm_nfa.sv
`default_nettype none
// One automaton step over all positions for one text byte.
module pgm_nfa (
    input  wire logic [pgm_pkg::MaxElements:0]        i_active,
    input  wire logic [pgm_pkg::ElemW-1:0]            i_count,
    input  wire pgm_pkg::t_kind                       i_kind [pgm_pkg::MaxElements],
    input  wire logic [7:0]                           i_char [pgm_pkg::MaxElements],
    input  wire logic [pgm_pkg::MaxClasses-1:0][255:0] i_bitmap,
    input  wire logic [7:0]                           i_byte,
    input  wire logic                                 i_sep,
    output logic      [pgm_pkg::MaxElements:0]        o_closed,
    output logic      [pgm_pkg::MaxElements:0]        o_next
);
    logic [pgm_pkg::MaxElements-1:0] w_star;
    logic [pgm_pkg::MaxElements-1:0] w_go;
    logic [pgm_pkg::MaxElements-1:0] w_stay;

    always_comb begin
        for (int i = 0; i < pgm_pkg::MaxElements; i++) begin
            w_star[i] = (i_count > pgm_pkg::ElemW'(i)) && (i_kind[i] == pgm_pkg::K_STAR);
        end
        // star chain: carry through consecutive stars
        o_closed[0] = i_active[0];
        for (int i = 0; i < pgm_pkg::MaxElements; i++) begin
            o_closed[i+1] = i_active[i+1] | (w_star[i] & o_closed[i]);
        end
    end

    always_comb begin
        logic hit;
        for (int i = 0; i < pgm_pkg::MaxElements; i++) begin
            hit = i_bitmap[i_char[i][pgm_pkg::ClassW-1:0]][i_byte];
            w_go[i]   = 1'b0;
            w_stay[i] = 1'b0;
            if (o_closed[i] && (i_count > pgm_pkg::ElemW'(i))) begin
                case (i_kind[i])
                    pgm_pkg::K_LIT:   w_go[i] = (i_char[i] == i_byte);
                    pgm_pkg::K_ONE:   w_go[i] = !i_sep;
                    pgm_pkg::K_STAR:  w_stay[i] = !i_sep;
                    pgm_pkg::K_CLASS: w_go[i] = !i_sep && hit;
                    pgm_pkg::K_INV:   w_go[i] = !i_sep && !hit;
                    default:          w_go[i] = 1'b0;
                endcase
            end
        end
        o_next = {w_go, 1'b0} | {1'b0, w_stay} | {{pgm_pkg::MaxElements{1'b0}}, i_sep};
    end
endmodule
`default_nettype wire

>>> test/tb.sv
module tb;
    import pgm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = A_PAT_BYTE;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [5:0]  o_element_total;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    path_glob_matcher_top dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic          sep_set;
    t_kind         el_kind [MaxElements];
    logic [7:0]    el_char [MaxElements];
    logic [63:0]   cls_map [MaxClasses*4];
    logic [63:0]   act;
    t_mode         pmode;
    int            el_cnt, cls_cnt;
    logic [1:0]    perr;
    logic          hit, closed;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] total;
    } t_result;
    t_result result_q[$];

    int errors = 0;
    int send_idle = 0, recv_idle = 0;

    function automatic logic is_sep(logic [7:0] b);
        return b == ChSlash || (sep_set && (b == ChBslash || b == ChColon));
    endfunction

    function automatic logic cls_has(logic [7:0] idx, logic [7:0] b);
        if (idx >= MaxClasses) return 1'b0;
        return cls_map[idx*4 + b[7:6]][b[5:0]];
    endfunction

    function automatic logic [63:0] star_close(logic [63:0] a);
        for (int i = 0; i < el_cnt; i++)
            if (el_kind[i] == K_STAR && a[i]) a[i+1] = 1'b1;
        return a;
    endfunction

    task automatic clear_pattern();
        for (int i = 0; i < MaxElements; i++) begin
            el_kind[i] = K_LIT;
            el_char[i] = 8'd0;
        end
        for (int i = 0; i < MaxClasses*4; i++) cls_map[i] = 64'd0;
        act = 64'd1; pmode = M_NORMAL; el_cnt = 0; cls_cnt = 0;
        perr = ErrNone; hit = 1'b0; closed = 1'b0;
    endtask

    task automatic push_elem(t_kind k, logic [7:0] c);
        if (el_cnt >= MaxElements) begin
            perr = ErrLong;
        end else begin
            el_kind[el_cnt] = k; el_char[el_cnt] = c; el_cnt++;
        end
    endtask

    task automatic cls_add(logic [7:0] b);
        if (cls_cnt == 0 || cls_cnt > MaxClasses) return;
        cls_map[(cls_cnt-1)*4 + b[7:6]][b[5:0]] = 1'b1;
    endtask

    task automatic parse_pat(logic [7:0] b);
        case (pmode)
            M_ESCAPE: begin
                pmode = M_NORMAL;
                push_elem(K_LIT, b);
            end
            M_CLASS_FIRST: begin
                if (b == ChBang) begin
                    if (el_cnt > 0) el_kind[el_cnt-1] = K_INV;
                    pmode = M_CLASS_BODY;
                end else if (b == ChRBrack) begin
                    pmode = M_NORMAL;
                end else begin
                    cls_add(b);
                    pmode = M_CLASS_BODY;
                end
            end
            M_CLASS_BODY: begin
                if (b == ChRBrack) pmode = M_NORMAL;
                else cls_add(b);
            end
            default: begin
                if (b == ChBslash) pmode = M_ESCAPE;
                else if (b == ChStar) push_elem(K_STAR, 8'd0);
                else if (b == ChQuest) push_elem(K_ONE, 8'd0);
                else if (b == ChLBrack) begin
                    if (el_cnt >= MaxElements || cls_cnt >= MaxClasses) begin
                        perr = ErrLong;
                    end else begin
                        for (int j = 0; j < 4; j++) cls_map[cls_cnt*4 + j] = 64'd0;
                        push_elem(K_CLASS, 8'(cls_cnt));
                        cls_cnt++;
                        pmode = M_CLASS_FIRST;
                    end
                end else push_elem(K_LIT, b);
            end
        endcase
    endtask

    task automatic step_text(logic [7:0] b);
        logic [63:0] a, n;
        logic s, go;
        a = star_close(act);
        n = 64'd0;
        s = is_sep(b);
        if (s && a[el_cnt]) hit = 1'b1;
        for (int i = 0; i < el_cnt; i++) begin
            go = 1'b0;
            if (a[i]) begin
                case (el_kind[i])
                    K_LIT:   go = el_char[i] == b;
                    K_ONE:   go = !s;
                    K_STAR:  if (!s) n[i] = 1'b1;
                    K_CLASS: go = !s && cls_has(el_char[i], b);
                    K_INV:   go = !s && !cls_has(el_char[i], b);
                    default: go = 1'b0;
                endcase
                if (go) n[i+1] = 1'b1;
            end
        end
        if (s) n[0] = 1'b1;
        act = n;
    endtask

    task automatic predict_word(t_action a, logic [7:0] b);
        t_result r;
        logic [63:0] c;
        case (a)
            A_PAT_BYTE: begin
                if (closed) clear_pattern();
                if (perr == ErrNone) parse_pat(b);
            end
            A_PAT_END: begin
                if (closed) clear_pattern();
                if (perr == ErrNone && pmode != M_NORMAL) perr = ErrInvalid;
                closed = 1'b1; act = 64'd1; hit = 1'b0;
                r.status = {1'b0, perr}; r.total = 6'(el_cnt);
                result_q = {result_q, r};
            end
            A_TXT_BYTE: if (closed && perr == ErrNone) step_text(b);
            default: begin
                if (!closed) r.status = StNoMatch;
                else if (perr != ErrNone) r.status = {1'b0, perr};
                else begin
                    c = star_close(act);
                    r.status = (el_cnt == 0 || hit || c[el_cnt]) ? StMatch : StNoMatch;
                end
                r.total = 6'(el_cnt);
                act = 64'd1; hit = 1'b0;
                result_q = {result_q, r};
            end
        endcase
    endtask

    // valid drops only on an idle gap or in drain, so it gets one update per edge
    task automatic send_word(t_action a, logic [7:0] b);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= a;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_word(a, b);
    endtask

    task automatic send_str(t_action a, string s);
        for (int i = 0; i < s.len(); i++) send_word(a, s[i]);
    endtask

    task automatic pat(string s);
        send_str(A_PAT_BYTE, s);
        send_word(A_PAT_END, 8'd0);
    endtask

    task automatic txt(string s);
        send_str(A_TXT_BYTE, s);
        send_word(A_TXT_END, 8'($urandom));
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result status=%0d total=%0d",
                                           o_status, o_element_total);
            end else begin
                want = result_q.pop_front();
                if (o_status !== want.status || o_element_total !== want.total) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp status=%0d total=%0d got status=%0d total=%0d",
                                 want.status, want.total, o_status, o_element_total);
                end
            end
        end
        i_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    task automatic drain();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sep(logic v);
        drain();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 2'd0; pwdata <= {31'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sep_set = v;
    endtask

    task automatic test_directed();
        pat("");            txt("abc");
        pat("a*c");         txt("abbc"); txt("ab/c"); txt("ac/x");
        pat("?[ab][!x]\\*"); txt("bax*"); txt("/ax*"); txt("b\377\000*");
        pat("[!]x");        txt("qx");
        pat("[]q");         txt("q");
        pat("ab\\");        txt("ab");
        pat("[ab");
        send_word(A_PAT_END, 8'hFF);
        txt("x");
        send_str(A_PAT_BYTE, "a/b");
        send_word(A_TXT_END, 8'd0);
        send_word(A_PAT_END, 8'd0);
        pat("[a][b][c][d][e]"); txt("abcd");
        pat("0123456789abcdefghijklmnopqrstuvwxyz"); txt("0123");
        pat("a:b");         txt("a:b"); txt("x\\a:b");
        pat("*b");          txt("a\\b:b/");
    endtask

    function automatic logic [7:0] rnd_char();
        case ($urandom_range(9))
            0: return ChSlash;
            1: return ChColon;
            2: return ChBslash;
            3: return 8'($urandom);
            // lower case a, b or c
            default: return 8'(8'h61 + $urandom_range(2));
        endcase
    endfunction

    task automatic test_random(int words);
        int n = 0;
        while (n < words) begin
            int plen;
            if ($urandom_range(9) == 0) begin
                send_word(t_action'($urandom_range(3)), 8'($urandom));
                n++;
                continue;
            end
            plen = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(6);
            for (int i = 0; i < plen; i++) begin
                logic [7:0] b;
                case ($urandom_range(11))
                    0: b = ChStar;
                    1: b = ChQuest;
                    2: b = ChLBrack;
                    3: b = ChRBrack;
                    4: b = ChBang;
                    5: b = ChBslash;
                    default: b = rnd_char();
                endcase
                send_word(A_PAT_BYTE, b);
            end
            send_word(A_PAT_END, 8'($urandom));
            n += plen + 1;
            repeat ($urandom_range(3)) begin
                int tl = $urandom_range(8);
                for (int i = 0; i < tl; i++) send_word(A_TXT_BYTE, rnd_char());
                send_word(A_TXT_END, 8'($urandom));
                n += tl + 1;
            end
        end
    endtask

    initial begin
        sep_set = 1'b0;
        clear_pattern();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        write_sep(1'b1);
        test_directed();
        send_idle = 34; recv_idle = 58;
        test_random(120);
        write_sep(1'b0);
        send_idle = 58; recv_idle = 34;
        test_random(120);
        write_sep(1'b1);
        send_idle = 0; recv_idle = 0;
        test_random(100);
        drain();
        if (errors == 0 && result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

>>> filelist.f
src/pgm_pkg.sv
src/pgm_nfa.sv
src/path_glob_matcher_top.sv
test/tb.sv
